### rtl/bracketed_root_finder_defines.svh
// Assertion macros for the bracketed root finder.
// Used by the top level only; the macros expand to nothing under synthesis.
`ifndef BRACKETED_ROOT_FINDER_DEFINES_SVH
`define BRACKETED_ROOT_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
`define BRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bracketed_root_finder: assertion failed");
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bracketed_root_finder: assertion failed");
`else
`define BRF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/brf_pkg.sv
// Shared types, codes and the step microprogram of the bracketed root finder.
// No dependencies; the datapath, controller, top level and testbench import it.
`default_nettype none
package brf_pkg;

    localparam int VALUE_WIDTH_DEFAULT   = 64;
    localparam int FRACTION_BITS_DEFAULT = 40;

    localparam logic [62:0] TOLERANCE_RESET      = 63'd1099;
    localparam logic [15:0] MAX_ITERATIONS_RESET = 16'd100;

    localparam logic CFG_TOLERANCE      = 1'b0;
    localparam logic CFG_MAX_ITERATIONS = 1'b1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    localparam logic [4:0] PC_QUADRATIC = 5'd0;
    localparam logic [4:0] PC_SECANT    = 5'd20;

    typedef struct packed {
        logic        command;
        logic [63:0] lower_point;
        logic [63:0] upper_point;
        logic [63:0] lower_value;
        logic [63:0] upper_value;
        logic [63:0] sample_value;
    } brf_in_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [63:0] point;
    } brf_out_t;

    typedef enum logic [1:0] {
        OUTCOME_EVALUATE,
        OUTCOME_ROOT,
        OUTCOME_NOT_BRACKETED,
        OUTCOME_NO_CONVERGENCE
    } brf_outcome_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_START,
        OP_LOAD_REPLY,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_DECIDE,
        OP_RESULT
    } brf_op_t;

    typedef enum logic [3:0] {
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_FA,
        SRC_FB,
        SRC_FC,
        SRC_T0,
        SRC_T1,
        SRC_T2
    } brf_src_t;

    typedef enum logic [1:0] {
        DST_T0,
        DST_T1,
        DST_T2,
        DST_S
    } brf_dst_t;

    typedef enum logic [2:0] {
        PT_ZERO,
        PT_S,
        PT_B,
        PT_IN_A,
        PT_IN_B,
        PT_MINUS_ONE
    } brf_point_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_WAIT,
        ST_DECIDE,
        ST_EMIT
    } brf_state_t;

    typedef struct packed {
        brf_op_t  op;
        brf_src_t x;
        brf_src_t y;
        brf_dst_t dst;
        logic     last;
    } brf_uop_t;

    typedef struct packed {
        brf_op_t        op;
        brf_src_t       x;
        brf_src_t       y;
        brf_dst_t       dst;
        brf_outcome_t   outcome;
        brf_point_sel_t point_sel;
    } brf_cmd_t;

    typedef struct packed {
        logic start_opposite;
        logic start_fb_zero;
        logic start_fa_zero;
        logic active;
        logic iter_limit;
        logic converged;
        logic use_quadratic;
        logic unit_done;
    } brf_status_t;

    function automatic brf_uop_t brf_mk(input brf_op_t op, input brf_src_t x,
                                        input brf_src_t y, input brf_dst_t dst,
                                        input logic last);
        brf_uop_t u;
        u.op   = op;
        u.x    = x;
        u.y    = y;
        u.dst  = dst;
        u.last = last;
        return u;
    endfunction

    // Inverse quadratic step from PC_QUADRATIC, secant step from PC_SECANT.
    function automatic brf_uop_t brf_uop(input logic [4:0] pc);
        brf_uop_t u;
        unique case (pc)
            5'd0:  u = brf_mk(OP_SUB, SRC_FA, SRC_FB, DST_T0, 1'b0);
            5'd1:  u = brf_mk(OP_DIV, SRC_FB, SRC_T0, DST_T0, 1'b0);
            5'd2:  u = brf_mk(OP_SUB, SRC_FA, SRC_FC, DST_T1, 1'b0);
            5'd3:  u = brf_mk(OP_DIV, SRC_FC, SRC_T1, DST_T1, 1'b0);
            5'd4:  u = brf_mk(OP_MUL, SRC_T0, SRC_T1, DST_T0, 1'b0);
            5'd5:  u = brf_mk(OP_MUL, SRC_A,  SRC_T0, DST_T2, 1'b0);
            5'd6:  u = brf_mk(OP_SUB, SRC_FB, SRC_FA, DST_T0, 1'b0);
            5'd7:  u = brf_mk(OP_DIV, SRC_FA, SRC_T0, DST_T0, 1'b0);
            5'd8:  u = brf_mk(OP_SUB, SRC_FB, SRC_FC, DST_T1, 1'b0);
            5'd9:  u = brf_mk(OP_DIV, SRC_FC, SRC_T1, DST_T1, 1'b0);
            5'd10: u = brf_mk(OP_MUL, SRC_T0, SRC_T1, DST_T0, 1'b0);
            5'd11: u = brf_mk(OP_MUL, SRC_B,  SRC_T0, DST_T0, 1'b0);
            5'd12: u = brf_mk(OP_ADD, SRC_T2, SRC_T0, DST_T2, 1'b0);
            5'd13: u = brf_mk(OP_SUB, SRC_FC, SRC_FA, DST_T0, 1'b0);
            5'd14: u = brf_mk(OP_DIV, SRC_FA, SRC_T0, DST_T0, 1'b0);
            5'd15: u = brf_mk(OP_SUB, SRC_FC, SRC_FB, DST_T1, 1'b0);
            5'd16: u = brf_mk(OP_DIV, SRC_FB, SRC_T1, DST_T1, 1'b0);
            5'd17: u = brf_mk(OP_MUL, SRC_T0, SRC_T1, DST_T0, 1'b0);
            5'd18: u = brf_mk(OP_MUL, SRC_C,  SRC_T0, DST_T0, 1'b0);
            5'd19: u = brf_mk(OP_ADD, SRC_T2, SRC_T0, DST_S,  1'b1);
            5'd20: u = brf_mk(OP_SUB, SRC_FB, SRC_FA, DST_T0, 1'b0);
            5'd21: u = brf_mk(OP_DIV, SRC_FB, SRC_T0, DST_T0, 1'b0);
            5'd22: u = brf_mk(OP_SUB, SRC_B,  SRC_A,  DST_T1, 1'b0);
            5'd23: u = brf_mk(OP_MUL, SRC_T0, SRC_T1, DST_T0, 1'b0);
            5'd24: u = brf_mk(OP_SUB, SRC_B,  SRC_T0, DST_S,  1'b1);
            default: u = brf_mk(OP_NONE, SRC_A, SRC_A, DST_T0, 1'b1);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

### rtl/brf_mul.sv
// Shift-and-add fixed point multiplier, one multiplier bit per cycle.
// Depends on nothing; the product is truncated toward zero and saturated.
`default_nettype none
module brf_mul #(
    parameter int VALUE_WIDTH   = 64,
    parameter int FRACTION_BITS = 40
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [VALUE_WIDTH-1:0] x,
    input  wire logic signed [VALUE_WIDTH-1:0] y,
    output logic                               done,
    output logic signed [VALUE_WIDTH-1:0]      result
);
    localparam int W     = VALUE_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int CNT_W = $clog2(W);
    localparam logic [2*W-1:0] VMAX_WIDE = {{(W+1){1'b0}}, {(W-1){1'b1}}};

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [2*W-1:0]   mcand_reg, mcand_next;
    logic [W-1:0]     mplier_reg, mplier_next;
    logic [2*W-1:0]   acc_reg, acc_next;
    logic [W-1:0]     mag_x, mag_y;
    logic [2*W-1:0]   scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    always_comb
    begin
        mag_x       = x[W-1] ? W'(-x) : W'(x);
        mag_y       = y[W-1] ? W'(-y) : W'(y);
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            neg_next    = x[W-1] ^ y[W-1];
            mcand_next  = {{W{1'b0}}, mag_x};
            mplier_next = mag_y;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // The magnitude of the most negative value is one more than the largest positive one.
    always_comb
    begin
        scaled = acc_reg >> F;
        if (!neg_reg)
        begin
            result = (scaled > VMAX_WIDE) ? {1'b0, {(W-1){1'b1}}} : W'(scaled);
        end
        else
        begin
            result = (scaled > VMAX_WIDE) ? {1'b1, {(W-1){1'b0}}} : W'(-scaled);
        end
    end

    assign done = done_reg;
endmodule
`default_nettype wire

### rtl/brf_div.sv
// Restoring fixed point divider, one quotient bit per cycle.
// Depends on nothing; quotients truncate toward zero and saturate.
`default_nettype none
module brf_div #(
    parameter int VALUE_WIDTH   = 64,
    parameter int FRACTION_BITS = 40
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [VALUE_WIDTH-1:0] n,
    input  wire logic signed [VALUE_WIDTH-1:0] d,
    output logic                               done,
    output logic signed [VALUE_WIDTH-1:0]      result
);
    localparam int W     = VALUE_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int QW    = W + F;
    localparam int CNT_W = $clog2(QW);
    localparam logic [QW-1:0] VMAX_WIDE = {{(F+1){1'b0}}, {(W-1){1'b1}}};

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             zero_div_reg, zero_div_next;
    logic             n_zero_reg, n_zero_next;
    logic             n_neg_reg, n_neg_next;
    logic [W-1:0]     den_reg, den_next;
    logic [QW-1:0]    num_reg, num_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [W:0]       rem_reg, rem_next;
    logic [W:0]       rem_shift;
    logic [W-1:0]     mag_n, mag_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        zero_div_reg <= zero_div_next;
        n_zero_reg   <= n_zero_next;
        n_neg_reg    <= n_neg_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
    end

    always_comb
    begin
        mag_n         = n[W-1] ? W'(-n) : W'(n);
        mag_d         = d[W-1] ? W'(-d) : W'(d);
        busy_next     = busy_reg;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        zero_div_next = zero_div_reg;
        n_zero_next   = n_zero_reg;
        n_neg_next    = n_neg_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        rem_shift     = {rem_reg[W-1:0], num_reg[QW-1]};
        if (start)
        begin
            neg_next      = n[W-1] ^ d[W-1];
            zero_div_next = (d == '0);
            n_zero_next   = (n == '0);
            n_neg_next    = n[W-1];
            den_next      = mag_d;
            num_next      = {mag_n, {F{1'b0}}};
            quo_next      = '0;
            rem_next      = '0;
            cnt_next      = '0;
            // A zero divisor needs no iteration: the answer follows from the numerator.
            busy_next     = (d != '0);
            done_next     = (d == '0);
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_shift - {1'b0, den_reg};
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QW-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (zero_div_reg)
        begin
            if (n_zero_reg)
            begin
                result = '0;
            end
            else
            begin
                result = n_neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
        end
        else if (!neg_reg)
        begin
            result = (quo_reg > VMAX_WIDE) ? {1'b0, {(W-1){1'b1}}} : W'(quo_reg);
        end
        else
        begin
            result = (quo_reg > VMAX_WIDE) ? {1'b1, {(W-1){1'b0}}} : W'(-quo_reg);
        end
    end

    assign done = done_reg;
endmodule
`default_nettype wire

### rtl/brf_datapath.sv
// Datapath: search state, configuration, saturating arithmetic and result register.
// Depends on brf_pkg, brf_mul and brf_div.
`default_nettype none
module brf_datapath #(
    parameter int VALUE_WIDTH   = 64,
    parameter int FRACTION_BITS = 40
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire brf_pkg::brf_cmd_t     cmd,
    input  wire brf_pkg::brf_in_t      in_item,
    input  wire logic                  cfg_write,
    input  wire logic                  cfg_index,
    input  wire logic [62:0]           cfg_data,
    output brf_pkg::brf_status_t       status,
    output brf_pkg::brf_out_t          out_item
);
    import brf_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam int F = FRACTION_BITS;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] MINUS_ONE =
        (F >= W - 1) ? VMIN : W'(-(64'sd1 <<< F));

    function automatic logic signed [W-1:0] clampw(input logic [63:0] v);
        logic [63-(W-1):0] hi;
        hi = v[63:W-1];
        if ((&hi) || !(|hi))
        begin
            return v[W-1:0];
        end
        return v[63] ? VMIN : VMAX;
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [W:0] v);
        if (v[W] != v[W-1])
        begin
            return v[W] ? VMIN : VMAX;
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] p,
                                                 input logic signed [W-1:0] q);
        logic signed [W:0] s;
        s = {p[W-1], p} + {q[W-1], q};
        return sat(s);
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] p,
                                                 input logic signed [W-1:0] q);
        logic signed [W:0] s;
        s = {p[W-1], p} - {q[W-1], q};
        return sat(s);
    endfunction

    function automatic logic signed [W-1:0] fmean(input logic signed [W-1:0] p,
                                                  input logic signed [W-1:0] q);
        return (p & q) + ((p ^ q) >>> 1);
    endfunction

    function automatic logic [W-1:0] distance(input logic signed [W-1:0] p,
                                              input logic signed [W-1:0] q);
        return (p >= q) ? W'(p - q) : W'(q - p);
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] p);
        return p[W-1] ? W'(-p) : W'(p);
    endfunction

    function automatic logic [63:0] widen(input logic [W-1:0] p);
        logic [63:0] r;
        r = '0;
        r[W-1:0] = p;
        return r;
    endfunction

    function automatic logic opposite(input logic signed [W-1:0] p,
                                      input logic signed [W-1:0] q);
        return (p < 0 && q > 0) || (p > 0 && q < 0);
    endfunction

    logic signed [W-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic signed [W-1:0] fa_reg, fa_next, fb_reg, fb_next, fc_reg, fc_next;
    logic signed [W-1:0] s_reg, s_next;
    logic signed [W-1:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic                flag_reg, flag_next;
    logic                active_reg, active_next;
    logic [15:0]         count_reg, count_next;
    logic [62:0]         tol_reg;
    logic [15:0]         max_iter_reg;
    brf_dst_t            dst_reg, dst_next;
    brf_out_t            res_reg, res_next;

    logic signed [W-1:0] opx, opy, wval;
    logic signed [W-1:0] in_a, in_b, in_fa, in_fb, in_fs;
    logic signed [W-1:0] na, nb, nfa, nfb;
    logic signed [W-1:0] q, qlo, qhi, pt;
    logic [W-1:0]        sb, bc, cd;
    logic                bis, wen;
    logic                mul_done, div_done;
    logic signed [W-1:0] mul_res, div_res;

    brf_mul #(.VALUE_WIDTH(W), .FRACTION_BITS(F)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(cmd.op == OP_MUL), .x(opx), .y(opy),
        .done(mul_done), .result(mul_res)
    );

    brf_div #(.VALUE_WIDTH(W), .FRACTION_BITS(F)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.op == OP_DIV), .n(opx), .d(opy),
        .done(div_done), .result(div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg        <= '0;
            b_reg        <= '0;
            c_reg        <= '0;
            d_reg        <= '0;
            fa_reg       <= '0;
            fb_reg       <= '0;
            fc_reg       <= '0;
            s_reg        <= '0;
            flag_reg     <= 1'b1;
            active_reg   <= 1'b0;
            count_reg    <= '0;
            dst_reg      <= DST_T0;
            tol_reg      <= TOLERANCE_RESET;
            max_iter_reg <= MAX_ITERATIONS_RESET;
        end
        else
        begin
            a_reg      <= a_next;
            b_reg      <= b_next;
            c_reg      <= c_next;
            d_reg      <= d_next;
            fa_reg     <= fa_next;
            fb_reg     <= fb_next;
            fc_reg     <= fc_next;
            s_reg      <= s_next;
            flag_reg   <= flag_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            dst_reg    <= dst_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_TOLERANCE:      tol_reg      <= cfg_data;
                    CFG_MAX_ITERATIONS: max_iter_reg <= cfg_data[15:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        unique case (cmd.x)
            SRC_A:   opx = a_reg;
            SRC_B:   opx = b_reg;
            SRC_C:   opx = c_reg;
            SRC_FA:  opx = fa_reg;
            SRC_FB:  opx = fb_reg;
            SRC_FC:  opx = fc_reg;
            SRC_T0:  opx = t0_reg;
            SRC_T1:  opx = t1_reg;
            SRC_T2:  opx = t2_reg;
            default: opx = '0;
        endcase
        unique case (cmd.y)
            SRC_A:   opy = a_reg;
            SRC_B:   opy = b_reg;
            SRC_C:   opy = c_reg;
            SRC_FA:  opy = fa_reg;
            SRC_FB:  opy = fb_reg;
            SRC_FC:  opy = fc_reg;
            SRC_T0:  opy = t0_reg;
            SRC_T1:  opy = t1_reg;
            SRC_T2:  opy = t2_reg;
            default: opy = '0;
        endcase
    end

    always_comb
    begin
        in_a  = clampw(in_item.lower_point);
        in_b  = clampw(in_item.upper_point);
        in_fa = clampw(in_item.lower_value);
        in_fb = clampw(in_item.upper_value);
        in_fs = clampw(in_item.sample_value);

        // Where the sample lands decides which end of the bracket it replaces.
        if (opposite(fa_reg, in_fs))
        begin
            na  = a_reg;
            nfa = fa_reg;
            nb  = s_reg;
            nfb = in_fs;
        end
        else
        begin
            na  = s_reg;
            nfa = in_fs;
            nb  = b_reg;
            nfb = fb_reg;
        end

        q   = fmean(a_reg, fmean(a_reg, b_reg));
        qlo = (q < b_reg) ? q : b_reg;
        qhi = (q < b_reg) ? b_reg : q;
        sb  = distance(s_reg, b_reg);
        bc  = distance(b_reg, c_reg);
        cd  = distance(c_reg, d_reg);
        bis = (s_reg < qlo) || (s_reg > qhi);
        if (flag_reg)
        begin
            bis = bis || (sb >= (bc >> 1)) || (widen(bc) < {1'b0, tol_reg});
        end
        else
        begin
            bis = bis || (sb >= (cd >> 1)) || (widen(cd) < {1'b0, tol_reg});
        end

        unique case (cmd.point_sel)
            PT_ZERO:      pt = '0;
            PT_S:         pt = s_reg;
            PT_B:         pt = b_reg;
            PT_IN_A:      pt = in_a;
            PT_IN_B:      pt = in_b;
            PT_MINUS_ONE: pt = MINUS_ONE;
            default:      pt = '0;
        endcase
    end

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        fc_next     = fc_reg;
        s_next      = s_reg;
        t0_next     = t0_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        flag_next   = flag_reg;
        active_next = active_reg;
        count_next  = count_reg;
        dst_next    = dst_reg;
        res_next    = res_reg;
        wen         = 1'b0;
        wval        = '0;

        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_LOAD_START:
            begin
                if (mag(in_fa) < mag(in_fb))
                begin
                    a_next  = in_b;
                    fa_next = in_fb;
                    b_next  = in_a;
                    fb_next = in_fa;
                    c_next  = in_b;
                    fc_next = in_fb;
                end
                else
                begin
                    a_next  = in_a;
                    fa_next = in_fa;
                    b_next  = in_b;
                    fb_next = in_fb;
                    c_next  = in_a;
                    fc_next = in_fa;
                end
                d_next     = '0;
                s_next     = '0;
                flag_next  = 1'b1;
                count_next = 16'd1;
            end
            OP_LOAD_REPLY:
            begin
                d_next  = c_reg;
                c_next  = b_reg;
                fc_next = fb_reg;
                if (mag(nfa) < mag(nfb))
                begin
                    a_next  = nb;
                    fa_next = nfb;
                    b_next  = na;
                    fb_next = nfa;
                end
                else
                begin
                    a_next  = na;
                    fa_next = nfa;
                    b_next  = nb;
                    fb_next = nfb;
                end
                count_next = count_reg + 16'd1;
            end
            OP_ADD:
            begin
                wen  = 1'b1;
                wval = sadd(opx, opy);
            end
            OP_SUB:
            begin
                wen  = 1'b1;
                wval = ssub(opx, opy);
            end
            OP_MUL, OP_DIV:
            begin
                dst_next = cmd.dst;
            end
            OP_DECIDE:
            begin
                flag_next = bis;
                if (bis)
                begin
                    s_next = fmean(a_reg, b_reg);
                end
            end
            OP_RESULT:
            begin
                res_next.outcome = cmd.outcome;
                res_next.point   = 64'(pt);
                active_next      = (cmd.outcome == OUTCOME_EVALUATE);
            end
            default:
            begin
            end
        endcase

        if (mul_done || div_done)
        begin
            wen  = 1'b1;
            wval = mul_done ? mul_res : div_res;
        end

        if (wen)
        begin
            unique case ((mul_done || div_done) ? dst_reg : cmd.dst)
                DST_T0: t0_next = wval;
                DST_T1: t1_next = wval;
                DST_T2: t2_next = wval;
                DST_S:  s_next  = wval;
            endcase
        end
    end

    always_comb
    begin
        status.start_opposite = opposite(in_fa, in_fb);
        status.start_fb_zero  = (in_fb == '0);
        status.start_fa_zero  = (in_fa == '0);
        status.active         = active_reg;
        status.iter_limit     = (count_reg >= max_iter_reg);
        status.converged      = (widen(distance(b_reg, a_reg)) < {1'b0, tol_reg});
        status.use_quadratic  = (fa_reg != fc_reg) && (fb_reg != fc_reg);
        status.unit_done      = mul_done || div_done;
    end

    assign out_item = res_reg;
endmodule
`default_nettype wire

### rtl/brf_ctrl.sv
// Controller: accepts items, sequences the step microprogram, owns the output valid.
// Depends on brf_pkg.
`default_nettype none
module brf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_command,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire brf_pkg::brf_status_t  status,
    output brf_pkg::brf_cmd_t          cmd,
    output logic                       busy
);
    import brf_pkg::*;

    brf_state_t state_reg, state_next;
    logic [4:0] pc_reg, pc_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    brf_uop_t   uop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        uop            = brf_uop(pc_reg);
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        cmd.op         = OP_NONE;
        cmd.x          = uop.x;
        cmd.y          = uop.y;
        cmd.dst        = uop.dst;
        cmd.outcome    = OUTCOME_EVALUATE;
        cmd.point_sel  = PT_ZERO;

        unique case (state_reg)
            ST_IDLE:
            begin
                // An item is taken only when the result register can receive its answer.
                in_stall = !out_free;
                if (in_valid && out_free)
                begin
                    if (in_command == CMD_START)
                    begin
                        if (status.start_opposite)
                        begin
                            cmd.op     = OP_LOAD_START;
                            state_next = ST_CHECK;
                        end
                        else
                        begin
                            cmd.op         = OP_RESULT;
                            out_valid_next = 1'b1;
                            priority if (status.start_fb_zero)
                            begin
                                cmd.outcome   = OUTCOME_ROOT;
                                cmd.point_sel = PT_IN_B;
                            end
                            else if (status.start_fa_zero)
                            begin
                                cmd.outcome   = OUTCOME_ROOT;
                                cmd.point_sel = PT_IN_A;
                            end
                            else
                            begin
                                cmd.outcome   = OUTCOME_NOT_BRACKETED;
                                cmd.point_sel = PT_ZERO;
                            end
                        end
                    end
                    else if (!status.active)
                    begin
                        cmd.op         = OP_RESULT;
                        cmd.outcome    = OUTCOME_NOT_BRACKETED;
                        cmd.point_sel  = PT_ZERO;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op     = OP_LOAD_REPLY;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                priority if (status.iter_limit)
                begin
                    cmd.op         = OP_RESULT;
                    cmd.outcome    = OUTCOME_NO_CONVERGENCE;
                    cmd.point_sel  = PT_MINUS_ONE;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (status.converged)
                begin
                    cmd.op         = OP_RESULT;
                    cmd.outcome    = OUTCOME_ROOT;
                    cmd.point_sel  = PT_B;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    pc_next    = status.use_quadratic ? PC_QUADRATIC : PC_SECANT;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.op = uop.op;
                if (uop.op == OP_MUL || uop.op == OP_DIV)
                begin
                    state_next = ST_WAIT;
                end
                else if (uop.last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    pc_next = pc_reg + 5'd1;
                end
            end
            ST_WAIT:
            begin
                if (status.unit_done)
                begin
                    if (uop.last)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 5'd1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_DECIDE:
            begin
                cmd.op     = OP_DECIDE;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.op         = OP_RESULT;
                cmd.outcome    = OUTCOME_EVALUATE;
                cmd.point_sel  = PT_S;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign busy      = (state_reg != ST_IDLE);
endmodule
`default_nettype wire

### rtl/bracketed_root_finder.sv
// An item with an immediate answer gives its result in the cycle after it is taken; a step
// runs the inverse quadratic or the secant microprogram through the bit-serial divider and
// multiplier, whose widths follow VALUE_WIDTH and FRACTION_BITS.
// Throughput: one item at a time; the next is taken once a step ends and the result register is free.
// Reset: asynchronous, clears control and search state and restores the configuration
// defaults; there is no clearing pass.
`default_nettype none
`include "bracketed_root_finder_defines.svh"
module bracketed_root_finder #(
    parameter int VALUE_WIDTH   = brf_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = brf_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire brf_pkg::brf_in_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output brf_pkg::brf_out_t      out_item,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [62:0]       cfg_data
);
    import brf_pkg::*;

    brf_cmd_t    cmd;
    brf_status_t status;
    logic        busy;

    brf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_command(in_item.command),
        .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .cmd(cmd), .busy(busy)
    );

    brf_datapath #(.VALUE_WIDTH(VALUE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_datapath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_item),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .status(status), .out_item(out_item)
    );

    // Every accepted item either answers at once or starts a step.
    `BRF_ASSERT_NEXT(a_accept_progress, clk, rst_n, in_valid && !in_stall, out_valid || busy)
    // While a step runs no result is pending and no item is taken.
    `BRF_ASSERT_NOW(a_busy_no_result, clk, rst_n, busy, !out_valid)
    `BRF_ASSERT_NOW(a_busy_stalls, clk, rst_n, busy, in_stall)
endmodule
`default_nettype wire

### tb/bracketed_root_finder_tb.sv
// Self-checking testbench for the bracketed root finder: acts as the host that evaluates f,
// predicts every result in fixed point and checks each one in order.
// Depends on brf_pkg and the bracketed_root_finder top level only.
`timescale 1ns / 1ps
module bracketed_root_finder_tb;
    import brf_pkg::*;

    localparam longint VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint VMIN = 64'sh8000_0000_0000_0000;
    localparam int FB = 40;
    localparam int ITEM_TARGET = 950;
    localparam int WATCHDOG_LIMIT = 60000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    brf_in_t in_item;
    logic out_valid;
    logic out_stall;
    brf_out_t out_item;
    logic cfg_write;
    logic cfg_index;
    logic [62:0] cfg_data;

    bracketed_root_finder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    brf_in_t  pending_items[$];
    brf_out_t expected_results[$];
    int fail_count;
    int items_sent;
    bit no_idle;
    bit long_hold_req;
    bit in_fire;
    bit out_fire;
    int send_gap;
    int stall_left;
    int hold_left;
    int quiet_cycles;

    // Predictor state.
    logic [62:0] tol_reg;
    logic [15:0] iter_limit_reg;
    longint pa, pb, pc, pd, pfa, pfb, pfc, ps;
    bit bis_flag;
    logic [15:0] iter_cnt;
    bit search_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] mag(longint x);
        return x < 0 ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    function automatic logic [63:0] distance(longint x, longint y);
        return x >= y ? 64'(x) - 64'(y) : 64'(y) - 64'(x);
    endfunction

    function automatic longint from_sign_mag(bit neg, logic [63:0] u, bit ovf);
        if (!neg)
            return (ovf || u[63]) ? VMAX : longint'(u);
        if (ovf || u >= 64'h8000_0000_0000_0000)
            return VMIN;
        return -longint'(u);
    endfunction

    function automatic longint sat65(logic signed [64:0] t);
        if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return VMAX;
        if (t < -65'sh0_8000_0000_0000_0000)
            return VMIN;
        return longint'(t[63:0]);
    endfunction

    function automatic longint q_add(longint x, longint y);
        return sat65(65'(x) + 65'(y));
    endfunction

    function automatic longint q_sub(longint x, longint y);
        return sat65(65'(x) - 65'(y));
    endfunction

    function automatic longint floor_mean(longint x, longint y);
        logic signed [64:0] t;
        t = 65'(x) + 65'(y);
        t = t >>> 1;
        return longint'(t[63:0]);
    endfunction

    function automatic longint q_mul(longint x, longint y);
        logic [127:0] p;
        p = {64'd0, mag(x)} * {64'd0, mag(y)};
        return from_sign_mag((x < 0) != (y < 0), p[FB+63:FB], |p[127:FB+64]);
    endfunction

    function automatic longint q_div(longint n, longint d);
        logic [127:0] num;
        logic [127:0] quo;
        if (d == 0)
            return n == 0 ? 0 : (n > 0 ? VMAX : VMIN);
        num = {64'd0, mag(n)} << FB;
        quo = num / {64'd0, mag(d)};
        return from_sign_mag((n < 0) != (d < 0), quo[63:0], |quo[127:64]);
    endfunction

    function automatic bit opposite(longint x, longint y);
        return (x < 0 && y > 0) || (x > 0 && y < 0);
    endfunction

    function automatic brf_out_t make_result(brf_outcome_t oc, longint p);
        brf_out_t r;
        r.outcome = oc;
        r.point = p;
        return r;
    endfunction

    function void keep_best_smaller();
        longint t;
        if (mag(pfa) < mag(pfb))
        begin
            t = pa; pa = pb; pb = t;
            t = pfa; pfa = pfb; pfb = t;
        end
    endfunction

    function brf_out_t next_step();
        longint s, q, qlo, qhi;
        bit bis;
        if (iter_cnt >= iter_limit_reg)
        begin
            search_on = 0;
            return make_result(OUTCOME_NO_CONVERGENCE, -(64'sd1 <<< FB));
        end
        if (distance(pb, pa) < {1'b0, tol_reg})
        begin
            search_on = 0;
            return make_result(OUTCOME_ROOT, pb);
        end
        if (pfa != pfc && pfb != pfc)
            s = q_add(q_add(
                q_mul(pa, q_mul(q_div(pfb, q_sub(pfa, pfb)), q_div(pfc, q_sub(pfa, pfc)))),
                q_mul(pb, q_mul(q_div(pfa, q_sub(pfb, pfa)), q_div(pfc, q_sub(pfb, pfc))))),
                q_mul(pc, q_mul(q_div(pfa, q_sub(pfc, pfa)), q_div(pfb, q_sub(pfc, pfb)))));
        else
            s = q_sub(pb, q_mul(q_div(pfb, q_sub(pfb, pfa)), q_sub(pb, pa)));
        q = floor_mean(pa, floor_mean(pa, pb));
        qlo = q < pb ? q : pb;
        qhi = q < pb ? pb : q;
        bis = s < qlo || s > qhi;
        if (bis_flag)
            bis = bis || distance(s, pb) >= (distance(pb, pc) >> 1)
                || distance(pb, pc) < {1'b0, tol_reg};
        else
            bis = bis || distance(s, pb) >= (distance(pc, pd) >> 1)
                || distance(pc, pd) < {1'b0, tol_reg};
        if (bis)
            s = floor_mean(pa, pb);
        bis_flag = bis;
        ps = s;
        search_on = 1;
        return make_result(OUTCOME_EVALUATE, s);
    endfunction

    function brf_out_t predict_result(brf_in_t it);
        longint fs;
        if (it.command == CMD_START)
        begin
            search_on = 0;
            if (!opposite(it.lower_value, it.upper_value))
            begin
                if (it.upper_value == 0)
                    return make_result(OUTCOME_ROOT, it.upper_point);
                if (it.lower_value == 0)
                    return make_result(OUTCOME_ROOT, it.lower_point);
                return make_result(OUTCOME_NOT_BRACKETED, 0);
            end
            pa = it.lower_point; pb = it.upper_point;
            pfa = it.lower_value; pfb = it.upper_value;
            keep_best_smaller();
            pc = pa; pfc = pfa;
            pd = 0; ps = 0;
            bis_flag = 1;
            iter_cnt = 1;
            return next_step();
        end
        if (!search_on)
            return make_result(OUTCOME_NOT_BRACKETED, 0);
        fs = it.sample_value;
        pd = pc;
        pc = pb;
        pfc = pfb;
        if (opposite(pfa, fs))
        begin
            pb = ps; pfb = fs;
        end
        else
        begin
            pa = ps; pfa = fs;
        end
        keep_best_smaller();
        iter_cnt = iter_cnt + 16'd1;
        return next_step();
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Host-side test functions of the search; kind 2 is pure noise.
    longint root_at, slope;
    int fn_kind;

    function longint host_f(longint x);
        longint u;
        u = q_sub(x, root_at);
        case (fn_kind)
            0: return q_mul(u, slope);
            1: return q_add(q_mul(q_mul(u, u), u), q_mul(u, slope));
            default: return rand64();
        endcase
    endfunction

    task automatic offer(brf_in_t it, output brf_out_t r);
        r = predict_result(it);
        pending_items.push_back(it);
        expected_results.push_back(r);
        items_sent++;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [62:0] val);
        drain();
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_TOLERANCE)
            tol_reg = val;
        else
            iter_limit_reg = val[15:0];
    endtask

    function automatic brf_in_t start_item(longint lo, longint hi, longint flo, longint fhi);
        brf_in_t it;
        it = rand64();
        it.command = CMD_START;
        it.lower_point = lo;
        it.upper_point = hi;
        it.lower_value = flo;
        it.upper_value = fhi;
        it.sample_value = rand64();
        return it;
    endfunction

    function automatic brf_in_t reply_item(longint fs);
        brf_in_t it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
        it.command = CMD_REPLY;
        it.sample_value = fs;
        return it;
    endfunction

    // One search: a bracket around a random root, then up to max_replies replies while points are requested.
    task automatic run_search(int max_replies);
        longint lo, hi;
        brf_out_t r;
        int n;
        fn_kind = $urandom_range(9) == 0 ? 2 : $urandom_range(1);
        root_at = longint'($urandom_range(32'hFFFF_FFFF)) <<< 13;
        slope = longint'($urandom_range(32'h3FFF_FFFF, 32'h0100_0000)) <<< 12;
        if ($urandom_range(1))
            slope = -slope;
        lo = q_sub(root_at, longint'($urandom_range(32'hFFFF_FFFF, 1)) <<< $urandom_range(14, 0));
        hi = q_add(root_at, longint'($urandom_range(32'hFFFF_FFFF, 1)) <<< $urandom_range(14, 0));
        if ($urandom_range(7) == 0)
            hi = lo + longint'($urandom_range(1000));
        offer(start_item(lo, hi, host_f(lo), host_f(hi)), r);
        n = 0;
        while (r.outcome == OUTCOME_EVALUATE && n < max_replies)
        begin
            offer(reply_item($urandom_range(31) == 0 ? rand64() : host_f(r.point)), r);
            n++;
        end
    endtask

    // Driver: one item per handshake, with a random gap before each new one unless no_idle is set.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_fire)
                ;
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                send_gap <= no_idle ? 0 : $urandom_range(7);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall pattern, including a long hold-off on request.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req && hold_left == 0)
            begin
                long_hold_req <= 1'b0;
                hold_left <= 400;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (out_fire)
            begin
                stall_left <= no_idle ? 0 : $urandom_range(7);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor, checker and watchdog.
    always @(posedge clk)
    begin
        brf_out_t want;
        in_fire <= in_valid && !in_stall;
        out_fire <= out_valid && !out_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: outcome %0d point %0h",
                           out_item.outcome, out_item.point);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item.outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, actual %0d", want.outcome,
                               out_item.outcome);
                        fail_count++;
                    end
                    if (out_item.point !== want.point)
                    begin
                        $error("point: expected %0h, actual %0h", want.point, out_item.point);
                        fail_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        brf_out_t r;
        int phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_TOLERANCE;
        cfg_data = '0;
        fail_count = 0;
        items_sent = 0;
        no_idle = 0;
        long_hold_req = 0;
        send_gap = 0;
        stall_left = 0;
        hold_left = 0;
        quiet_cycles = 0;
        tol_reg = TOLERANCE_RESET;
        iter_limit_reg = MAX_ITERATIONS_RESET;
        pa = 0; pb = 0; pc = 0; pd = 0; pfa = 0; pfb = 0; pfc = 0; ps = 0;
        bis_flag = 1;
        iter_cnt = 0;
        search_on = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with the reset configuration first.
        offer(reply_item(rand64()), r);                  // reply while idle
        offer(start_item(VMIN, VMAX, VMIN, VMAX), r);
        offer(reply_item(0), r);
        offer(start_item(VMAX, VMIN, VMAX, VMAX), r);   // same sign
        offer(start_item(-5, 7, 3, 0), r);              // upper value zero
        offer(start_item(-5, 7, 0, 3), r);              // lower value zero
        offer(start_item(-5, 7, 0, 0), r);
        offer(start_item(1 <<< FB, 2 <<< FB, -(1 <<< FB), 1 <<< FB), r);
        offer(reply_item(VMAX), r);
        offer(reply_item(VMIN), r);
        offer(start_item(0, 64'sd1 <<< 50, VMAX, VMIN), r);  // start while active
        offer(reply_item(-1), r);
        offer(reply_item(1), r);
        offer(start_item(100, 101, -1, 1), r);
        offer(reply_item(0), r);
        drain();
        write_cfg(CFG_MAX_ITERATIONS, 63'd1);
        offer(start_item(-(1 <<< FB), 1 <<< FB, -7, 9), r);
        write_cfg(CFG_TOLERANCE, 63'h7FFF_FFFF_FFFF_FFFF);
        write_cfg(CFG_MAX_ITERATIONS, 63'd65535);
        offer(start_item(VMIN, VMAX, -1, 1), r);
        offer(reply_item(5), r);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase % 5)
                0: begin write_cfg(CFG_TOLERANCE, 63'd1 <<< $urandom_range(30, 10));
                         write_cfg(CFG_MAX_ITERATIONS, $urandom_range(40, 2)); end
                1: begin write_cfg(CFG_TOLERANCE, 63'd0);
                         write_cfg(CFG_MAX_ITERATIONS, $urandom_range(12, 1)); end
                2: begin write_cfg(CFG_TOLERANCE, TOLERANCE_RESET);
                         write_cfg(CFG_MAX_ITERATIONS, MAX_ITERATIONS_RESET); end
                3: begin write_cfg(CFG_TOLERANCE, 63'({$urandom, $urandom}));
                         write_cfg(CFG_MAX_ITERATIONS, $urandom_range(30, 1)); end
                default: begin write_cfg(CFG_TOLERANCE, 63'd1 <<< $urandom_range(40, 20));
                         write_cfg(CFG_MAX_ITERATIONS, 63'd65535); end
            endcase
            no_idle = (phase % 3 == 2);
            if (phase == 1)
            begin
                // Hold the receiver off while immediate items keep arriving.
                long_hold_req = 1;
                repeat (8)
                    offer(start_item(rand64(), rand64(), 5, 5), r);
                repeat (4)
                    offer(reply_item(rand64()), r);
            end
            repeat (6)
            begin
                if ($urandom_range(5) == 0)
                    offer(start_item(rand64(), rand64(), rand64(), rand64()), r);
                else if ($urandom_range(9) == 0)
                    offer(reply_item(rand64()), r);
                run_search($urandom_range(40, 1));
            end
            if (phase == 2)
                drain();
            phase++;
        end

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
